// ===== sv/abkf_pkg.sv =====
// Shared types, register codes and saturation helper for the angle/bias Kalman filter.
// No dependencies; the multiplier, divider, filter unit and testbench import this package.
package abkf_pkg;

  // Operand width of the bit-serial multiplier and width of its rounded result.
  localparam int MulW  = 36;
  localparam int ProdW = 50;

  // Configuration register indexes.
  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

  // Reset values of the noise registers, Q0.24.
  localparam logic [23:0] RST_ANGLE_NOISE = 24'd16777;
  localparam logic [23:0] RST_BIAS_NOISE  = 24'd50332;
  localparam logic [23:0] RST_MEAS_NOISE  = 24'd503316;

  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
    logic        [23:0] time_step;
  } abkf_in_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] corrected_rate;
    logic signed [31:0] bias_estimate;
  } abkf_out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [23:0] data;
  } abkf_cfg_t;

  // Status of a multi-cycle arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [51:0] hi_lim;
    logic signed [51:0] lo_lim;
    hi_lim = 52'sd2147483647;
    lo_lim = -52'sd2147483648;
    if (v > hi_lim) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo_lim) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== sv/abkf_chan_if.sv =====
// Valid/ready channel carrying one payload beat.
// Payload type comes from the instantiating scope, normally a struct of abkf_pkg.
interface abkf_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/abkf_mul.sv =====
// Bit-serial signed multiplier with the Q24 round-to-nearest reduction folded in.
// Depends on abkf_pkg for widths and the unit status struct.
module abkf_mul import abkf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output unit_sts_t               sts_o,
  output logic signed [ProdW-1:0] prod_o
);

  localparam int CntW = $clog2(MulW);
  localparam int AccW = MulW + 2;
  localparam logic [CntW-1:0] LastCnt = CntW'(MulW - 1);
  // Half an LSB of the result, preloaded so it lands on bit 23 after all shifts.
  localparam logic signed [AccW-1:0] RndInit = AccW'(1) << 23;

  logic signed [MulW-1:0] a_q;
  logic        [MulW-1:0] b_q, b_d;
  logic signed [AccW-1:0] hi_q, hi_d;
  logic        [MulW-1:0] lo_q, lo_d;
  logic        [CntW-1:0] cnt_q;
  logic                   busy_q, done_q;
  logic signed [AccW-1:0] a_ext, addend, sum;
  logic                   last;

  // One multiplier bit per cycle; the top bit carries negative weight.
  always_comb begin
    last   = (cnt_q == LastCnt);
    a_ext  = {{2{a_q[MulW-1]}}, a_q};
    addend = '0;
    if (b_q[0]) begin
      addend = last ? -a_ext : a_ext;
    end
    sum  = hi_q + addend;
    hi_d = sum >>> 1;
    lo_d = {sum[0], lo_q[MulW-1:1]};
    b_d  = b_q >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and accumulator shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= RndInit;
      lo_q <= '0;
    end else if (busy_q) begin
      b_q  <= b_d;
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod_o     = {hi_q, lo_q[MulW-1:24]};
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== sv/abkf_div.sv =====
// Restoring divider for the Kalman gains: round(num * 2^24 / den), ties away from zero,
// saturated to 32 bits. One quotient bit per cycle. Depends on abkf_pkg.
module abkf_div import abkf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic        [31:0] den_i,
  output unit_sts_t          sts_o,
  output logic signed [31:0] quot_o
);

  localparam int DvdW = 57;
  localparam int CntW = $clog2(DvdW);
  localparam logic [CntW-1:0] LastCnt = CntW'(DvdW - 1);

  logic              neg_q;
  logic [DvdW-1:0]   dvd_q, quo_q;
  logic [32:0]       dsr_q, rem_q, rem_d;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q;
  logic [31:0]       mag;
  logic [DvdW-1:0]   dvd_init;
  logic [33:0]       trial;
  logic              fits;
  logic              ovf_pos, ovf_neg;
  logic [31:0]       neg_quo;

  // Dividend is (|num| << 25) + den over divisor 2*den, which gives the rounding.
  always_comb begin
    mag      = num_i[31] ? (~num_i + 32'd1) : num_i;
    dvd_init = {mag, 25'd0} + {25'd0, den_i};
  end

  // One restoring step.
  always_comb begin
    trial = {rem_q, dvd_q[DvdW-1]};
    fits  = (trial >= {1'b0, dsr_q});
    rem_d = fits ? 33'(trial - {1'b0, dsr_q}) : trial[32:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[31];
      dvd_q <= dvd_init;
      dsr_q <= {den_i, 1'b0};
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      quo_q <= {quo_q[DvdW-2:0], fits};
    end
  end

  // Apply the sign and saturate.
  always_comb begin
    ovf_pos = |quo_q[DvdW-1:31];
    ovf_neg = (|quo_q[DvdW-1:32]) || (quo_q[31] && (|quo_q[30:0]));
    neg_quo = ~quo_q[31:0] + 32'd1;
    if (neg_q) begin
      quot_o = ovf_neg ? 32'sh80000000 : neg_quo;
    end else begin
      quot_o = ovf_pos ? 32'sh7FFFFFFF : quo_q[31:0];
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== sv/angle_bias_kalman_filter_unit.sv =====
// Two-state angle and gyro-bias Kalman filter. Each input beat (measured angle and rate
// in Q16.16, time step in Q0.24) produces one output beat with the filtered angle, the
// bias-corrected rate and the bias estimate. An update runs ten products one after another
// through a bit-serial multiplier and the two gains through a restoring divider; when the
// innovation variance is not positive the divisions are skipped. One update is in flight
// at a time; the next input beat is taken once the result sits in the output register.
// The user must write the noise registers through the configuration channel only while
// the filter is idle; the block itself does not enforce this. The channel always accepts.
// Depends on abkf_pkg, abkf_chan_if, abkf_mul and abkf_div.
module angle_bias_kalman_filter_unit import abkf_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  abkf_chan_if.sink   in_i,
  abkf_chan_if.source out_o,
  abkf_chan_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef enum logic [3:0] {
    OP_PRED_ANGLE = 4'd0,
    OP_DTP11      = 4'd1,
    OP_PRED_AA    = 4'd2,
    OP_PRED_BB    = 4'd3,
    OP_GAIN0      = 4'd4,
    OP_GAIN1      = 4'd5,
    OP_CORR_ANGLE = 4'd6,
    OP_CORR_BIAS  = 4'd7,
    OP_CORR_AA    = 4'd8,
    OP_CORR_AB    = 4'd9,
    OP_CORR_BA    = 4'd10,
    OP_CORR_BB    = 4'd11
  } op_e;

  function automatic logic signed [MulW-1:0] sx36(input logic signed [31:0] v);
    return {{(MulW-32){v[31]}}, v};
  endfunction

  function automatic logic signed [51:0] sx52(input logic signed [31:0] v);
    return {{20{v[31]}}, v};
  endfunction

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [23:0]        apn_q, bpn_q, mn_q;
  logic signed [31:0] angle_q, bias_q, aa_q, ab_q, ba_q, bb_q;
  logic signed [31:0] ma_q, rate_q, y_q, k0_q, k1_q, p00_q, p01_q;
  logic [23:0]        dt_q;
  logic signed [33:0] dtp_q;
  logic               out_valid_q;
  abkf_out_t          out_q;

  logic                    mul_start, div_start;
  logic signed [MulW-1:0]  mul_a, mul_b, aa_arg;
  logic signed [ProdW-1:0] prod;
  logic signed [51:0]      pr52, dtp52;
  logic signed [32:0]      s_var;
  logic                    s_pos;
  logic signed [31:0]      div_num, quot;
  unit_sts_t               mul_sts, div_sts;
  logic                    in_fire, unit_done, out_free;

  abkf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sts_o   (mul_sts),
    .prod_o  (prod)
  );

  abkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_var[31:0]),
    .sts_o   (div_sts),
    .quot_o  (quot)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
  assign out_free    = !out_valid_q || out_o.ready;

  // Innovation variance and the predicted-angle covariance argument.
  always_comb begin
    s_var  = {aa_q[31], aa_q} + {9'd0, mn_q};
    s_pos  = !s_var[32] && (|s_var[31:0]);
    aa_arg = {{2{dtp_q[33]}}, dtp_q} - sx36(ab_q) - sx36(ba_q) + {12'd0, apn_q};
    pr52   = {{2{prod[ProdW-1]}}, prod};
    dtp52  = {{18{dtp_q[33]}}, dtp_q};
  end

  // Operand selection for the arithmetic units.
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = sx36(k0_q);
    mul_b     = sx36(y_q);
    div_num   = aa_q;
    if (state_q == ST_ISSUE) begin
      case (op_q)
        OP_PRED_ANGLE: begin
          mul_start = 1'b1;
          mul_a     = {12'd0, dt_q};
          mul_b     = sx36(rate_q);
        end
        OP_DTP11: begin
          mul_start = 1'b1;
          mul_a     = {12'd0, dt_q};
          mul_b     = sx36(bb_q);
        end
        OP_PRED_AA: begin
          mul_start = 1'b1;
          mul_a     = {12'd0, dt_q};
          mul_b     = aa_arg;
        end
        OP_PRED_BB: begin
          mul_start = 1'b1;
          mul_a     = {12'd0, bpn_q};
          mul_b     = {12'd0, dt_q};
        end
        OP_GAIN0: begin
          div_start = s_pos;
          div_num   = aa_q;
        end
        OP_GAIN1: begin
          div_start = 1'b1;
          div_num   = ba_q;
        end
        OP_CORR_ANGLE: begin
          mul_start = 1'b1;
          mul_a     = sx36(k0_q);
          mul_b     = sx36(y_q);
        end
        OP_CORR_BIAS: begin
          mul_start = 1'b1;
          mul_a     = sx36(k1_q);
          mul_b     = sx36(y_q);
        end
        OP_CORR_AA: begin
          mul_start = 1'b1;
          mul_a     = sx36(k0_q);
          mul_b     = sx36(p00_q);
        end
        OP_CORR_AB: begin
          mul_start = 1'b1;
          mul_a     = sx36(k0_q);
          mul_b     = sx36(p01_q);
        end
        OP_CORR_BA: begin
          mul_start = 1'b1;
          mul_a     = sx36(k1_q);
          mul_b     = sx36(p00_q);
        end
        OP_CORR_BB: begin
          mul_start = 1'b1;
          mul_a     = sx36(k1_q);
          mul_b     = sx36(p01_q);
        end
        default: begin
          mul_start = 1'b0;
        end
      endcase
    end
  end

  assign unit_done = (op_q == OP_GAIN0 || op_q == OP_GAIN1) ? div_sts.done : mul_sts.done;

  // Sequencer: issue one op, wait for its unit, write back, move on; gains skipped if !s_pos.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_ISSUE;
          op_d    = OP_PRED_ANGLE;
        end
      end
      ST_ISSUE: begin
        if (op_q == OP_GAIN0 && !s_pos) begin
          op_d = OP_CORR_ANGLE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (unit_done) begin
          if (op_q == OP_CORR_BB) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_ISSUE;
            op_d    = op_e'(4'(op_q + 4'd1));
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_PRED_ANGLE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apn_q <= RST_ANGLE_NOISE;
      bpn_q <= RST_BIAS_NOISE;
      mn_q  <= RST_MEAS_NOISE;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        REG_ANGLE_NOISE: apn_q <= cfg_i.payload.data;
        REG_BIAS_NOISE:  bpn_q <= cfg_i.payload.data;
        REG_MEAS_NOISE:  mn_q  <= cfg_i.payload.data;
        default:         apn_q <= apn_q;
      endcase
    end
  end

  // Filter state: angle, bias and covariance, written back after the operations that update them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      aa_q    <= '0;
      ab_q    <= '0;
      ba_q    <= '0;
      bb_q    <= '0;
    end else if (state_q == ST_WAIT && unit_done) begin
      case (op_q)
        OP_PRED_ANGLE: angle_q <= sat32(sx52(angle_q) + pr52);
        OP_PRED_AA: begin
          aa_q <= sat32(sx52(aa_q) + pr52);
          ab_q <= sat32(sx52(ab_q) - dtp52);
          ba_q <= sat32(sx52(ba_q) - dtp52);
        end
        OP_PRED_BB:    bb_q    <= sat32(sx52(bb_q) + pr52);
        OP_CORR_ANGLE: angle_q <= sat32(sx52(angle_q) + pr52);
        OP_CORR_BIAS:  bias_q  <= sat32(sx52(bias_q) + pr52);
        OP_CORR_AA:    aa_q    <= sat32(sx52(aa_q) - pr52);
        OP_CORR_AB:    ab_q    <= sat32(sx52(ab_q) - pr52);
        OP_CORR_BA:    ba_q    <= sat32(sx52(ba_q) - pr52);
        OP_CORR_BB:    bb_q    <= sat32(sx52(bb_q) - pr52);
        default:       angle_q <= angle_q;
      endcase
    end
  end

  // Per-update working values.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ma_q   <= in_i.payload.measured_angle;
      dt_q   <= in_i.payload.time_step;
      rate_q <= sat32(sx52(in_i.payload.measured_rate) - sx52(bias_q));
    end
    if (state_q == ST_ISSUE && op_q == OP_GAIN0) begin
      y_q   <= sat32(sx52(ma_q) - sx52(angle_q));
      p00_q <= aa_q;
      p01_q <= ab_q;
      if (!s_pos) begin
        k0_q <= '0;
        k1_q <= '0;
      end
    end
    if (state_q == ST_WAIT && unit_done) begin
      case (op_q)
        OP_DTP11: dtp_q <= prod[33:0];
        OP_GAIN0: k0_q  <= quot;
        OP_GAIN1: k1_q  <= quot;
        default:  dtp_q <= dtp_q;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_q.angle_estimate <= angle_q;
      out_q.corrected_rate <= rate_q;
      out_q.bias_estimate  <= bias_q;
    end
  end

  // The sequencer stays one-hot.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  // A unit is never restarted while it is still working.
  a_mul_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_sts.busy) else $error("multiplier started while busy");

  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy) else $error("divider started while busy");

  // Only one unit runs at a time.
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_sts.busy && div_sts.busy)) else $error("multiplier and divider both busy");

  // A new beat is never taken while an update is in flight.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !mul_sts.busy && !div_sts.busy) else $error("beat taken mid-update");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the angle and gyro-bias Kalman filter unit.
// Holds its own fixed-point predictor of the filter; depends on abkf_pkg,
// abkf_chan_if and the RTL of angle_bias_kalman_filter_unit.
module testbench import abkf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  abkf_chan_if #(.payload_t(abkf_in_t))  in_ch ();
  abkf_chan_if #(.payload_t(abkf_out_t)) out_ch ();
  abkf_chan_if #(.payload_t(abkf_cfg_t)) cfg_ch ();

  angle_bias_kalman_filter_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  always #6 clk_i = ~clk_i;

  // Filter state and noise settings as the predictor sees them.
  logic [23:0] q_angle, q_bias, r_meas;
  logic signed [31:0] est_angle, est_bias, p00, p01, p10, p11;

  abkf_out_t expected_q[$];
  int mismatch_cnt = 0;
  int idle_cycles = 0;
  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int stall_left = 0;

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Product brought back to Q.24 by rounding to nearest, ties toward plus infinity.
  function automatic longint mul_q24(longint a, longint b);
    return (a * b + (64'sd1 <<< 23)) >>> 24;
  endfunction

  // Gain num/den in Q8.24, rounded to nearest with ties away from zero.
  function automatic longint gain_q24(longint num, longint den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = ((mag << 25) + longint'(den)) / (longint'(den) << 1);
    return clamp_s32((num < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic void reset_filter_state();
    q_angle = RST_ANGLE_NOISE;
    q_bias = RST_BIAS_NOISE;
    r_meas = RST_MEAS_NOISE;
    est_angle = '0;
    est_bias = '0;
    p00 = '0;
    p01 = '0;
    p10 = '0;
    p11 = '0;
  endfunction

  // One filter update: predict, compute gains, correct. Returns the output beat.
  function automatic abkf_out_t kalman_update(abkf_in_t x);
    longint dt, rate, dtp11, s, k0, k1, innov, old00, old01;
    abkf_out_t res;
    dt = longint'(x.time_step);
    rate = clamp_s32(longint'(x.measured_rate) - est_bias);
    est_angle = 32'(clamp_s32(longint'(est_angle) + mul_q24(dt, rate)));
    dtp11 = mul_q24(dt, p11);
    p00 = 32'(clamp_s32(longint'(p00) + mul_q24(dt, dtp11 - p01 - p10 + longint'(q_angle))));
    p01 = 32'(clamp_s32(longint'(p01) - dtp11));
    p10 = 32'(clamp_s32(longint'(p10) - dtp11));
    p11 = 32'(clamp_s32(longint'(p11) + mul_q24(longint'(q_bias), dt)));
    k0 = 0;
    k1 = 0;
    s = longint'(p00) + longint'(r_meas);
    // A non-positive innovation variance leaves both gains at zero.
    if (s > 0) begin
      k0 = gain_q24(p00, s);
      k1 = gain_q24(p10, s);
    end
    innov = clamp_s32(longint'(x.measured_angle) - est_angle);
    est_angle = 32'(clamp_s32(longint'(est_angle) + mul_q24(k0, innov)));
    est_bias = 32'(clamp_s32(longint'(est_bias) + mul_q24(k1, innov)));
    old00 = p00;
    old01 = p01;
    p00 = 32'(clamp_s32(longint'(p00) - mul_q24(k0, old00)));
    p01 = 32'(clamp_s32(longint'(p01) - mul_q24(k0, old01)));
    p10 = 32'(clamp_s32(longint'(p10) - mul_q24(k1, old00)));
    p11 = 32'(clamp_s32(longint'(p11) - mul_q24(k1, old01)));
    res.angle_estimate = est_angle;
    res.corrected_rate = rate[31:0];
    res.bias_estimate = est_bias;
    return res;
  endfunction

  // Random gap length: mostly short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 95) return $urandom_range(4, 1);
    return $urandom_range(400, 40);
  endfunction

  // Result sink: random stalls on the output ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(9) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each output beat with the oldest expected result.
  always @(posedge clk_i) begin
    abkf_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("Unexpected output beat %p", out_ch.payload);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.payload.angle_estimate !== want.angle_estimate ||
            out_ch.payload.corrected_rate !== want.corrected_rate ||
            out_ch.payload.bias_estimate !== want.bias_estimate) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("Mismatch at %0t: angle exp %0d got %0d, rate exp %0d got %0d,",
                     $realtime, want.angle_estimate, out_ch.payload.angle_estimate,
                     want.corrected_rate, out_ch.payload.corrected_rate);
            $display("  bias exp %0d got %0d",
                     want.bias_estimate, out_ch.payload.bias_estimate);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one input beat and record its expected result on acceptance.
  task automatic send_sample(logic signed [31:0] angle, logic signed [31:0] rate,
                             logic [23:0] dt);
    abkf_in_t beat;
    int gap;
    beat.measured_angle = angle;
    beat.measured_rate = rate;
    beat.time_step = dt;
    in_ch.valid <= 1'b1;
    in_ch.payload <= beat;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_q.push_back(kalman_update(beat));
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Register write, only issued while the filter is idle.
  task automatic write_noise(logic [1:0] idx, logic [23:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: value};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ANGLE_NOISE: q_angle = value;
      REG_BIAS_NOISE:  q_bias = value;
      REG_MEAS_NOISE:  r_meas = value;
      default: ;
    endcase
  endtask

  // Realistic IMU sample: small angle and rate, millisecond-range step.
  task automatic send_plausible();
    send_sample($signed($urandom_range(180 << 16)) - (90 <<< 16),
                $signed($urandom_range(400 << 16)) - (200 <<< 16),
                24'($urandom_range(170000, 8000)));
  endtask

  task automatic send_noise_item();
    send_sample($urandom, $urandom, 24'($urandom_range(24'hFFFFFF)));
  endtask

  // Field extremes, zero and full time steps, saturation.
  task automatic test_field_extremes();
    send_sample(32'sd0, 32'sd0, 24'd0);
    send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF);
    send_sample(32'sh80000000, 32'sh80000000, 24'hFFFFFF);
    send_sample(32'sh80000000, 32'sh7FFFFFFF, 24'd0);
    send_sample(32'sh7FFFFFFF, 32'sh80000000, 24'd16777);
    send_sample(32'sd655360, -32'sd65536, 24'd1);
    send_sample(-32'sd1, 32'sd1, 24'hFFFFFF);
    repeat (4) send_plausible();
  endtask

  // Register writes at their extremes, zero noise and an ignored index.
  task automatic test_noise_registers();
    write_noise(REG_MEAS_NOISE, 24'd0);
    send_sample(32'sd0, 32'sd0, 24'd0);
    send_sample(32'sd3276800, 32'sd65536, 24'd16777);
    write_noise(REG_ANGLE_NOISE, 24'hFFFFFF);
    write_noise(REG_BIAS_NOISE, 24'hFFFFFF);
    write_noise(REG_MEAS_NOISE, 24'd1);
    repeat (3) send_plausible();
    write_noise(REG_ANGLE_NOISE, 24'd0);
    write_noise(REG_BIAS_NOISE, 24'd0);
    write_noise(REG_MEAS_NOISE, 24'hFFFFFF);
    repeat (3) send_plausible();
    write_noise(REG_UNUSED, 24'hABCDEF);
    send_plausible();
  endtask

  // Long random runs under several noise settings; mostly well-formed samples.
  task automatic test_random_tracking();
    for (int phase = 0; phase < 5; phase++) begin
      write_noise(REG_ANGLE_NOISE,
                  (phase == 0) ? RST_ANGLE_NOISE : 24'($urandom_range(24'hFFFFFF)));
      write_noise(REG_BIAS_NOISE,
                  (phase == 0) ? RST_BIAS_NOISE : 24'($urandom_range(24'hFFFFFF)));
      write_noise(REG_MEAS_NOISE,
                  (phase == 0) ? RST_MEAS_NOISE : 24'($urandom_range(24'hFFFFFF)));
      sender_gaps = (phase != 2);
      sink_stalls = (phase != 2);
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(9) == 0) send_noise_item();
        else send_plausible();
        // Hold off until the filter drains, once per phase.
        if (n == 100) wait_drained();
      end
    end
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    reset_filter_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_noise_registers();
    test_random_tracking();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
